/* src/fifo_job_queue_with_keyed_removal_unit_assert.svh */
// Assertion macros for the job queue checker.
`ifndef FIFO_JOB_QUEUE_WITH_KEYED_REMOVAL_UNIT_ASSERT_SVH
`define FIFO_JOB_QUEUE_WITH_KEYED_REMOVAL_UNIT_ASSERT_SVH

// a implies b in the same cycle
`define FJQ_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b in the next cycle
`define FJQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

/* src/fjq_pkg.sv */
`default_nettype none
package fjq_pkg;
    localparam int DefQueueDepth   = 16;
    localparam int DefPayloadWidth = 32;
    localparam int KeyWidth        = 32;
    localparam int OutPayWidth     = 32;

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_DEQ    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;
endpackage
`default_nettype wire

/* src/fifo_job_queue_with_keyed_removal_unit.sv */
`default_nettype none
// Job queue with removal by key; slots chained by links held in memory.
// A removal walks the chain from the head, one entry at a time, until the key
// matches or every held entry has been checked.
// Throughput: one request at a time; the next is taken once the result is out.
// Reset: rst_n asynchronous, active low, clears the free map, pointers and count;
// slot memories are left undefined and are only ever read after being written.
module fifo_job_queue_with_keyed_removal_unit #(
    parameter int QUEUE_DEPTH   = fjq_pkg::DefQueueDepth,
    parameter int PAYLOAD_WIDTH = fjq_pkg::DefPayloadWidth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // job_key[31:0], job_payload[63:32]
    input  wire logic [63:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // ok[0], out_key[32:1], out_payload[64:33], queue_count[69:65],
    // queue_empty[70], zero fill [71]
    output logic [71:0]      m_tdata
);
    import fjq_pkg::*;

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = (PAYLOAD_WIDTH < OutPayWidth) ? PAYLOAD_WIDTH : OutPayWidth;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CHECK, S_LINK, S_OUT
    } state_t;

    // slot memories: one write port, one registered read port
    logic [KeyWidth-1:0] key_mem  [QUEUE_DEPTH];
    logic [PW-1:0]       pay_mem  [QUEUE_DEPTH];
    logic [SW-1:0]       link_mem [QUEUE_DEPTH];

    state_t               state_reg;
    logic [QUEUE_DEPTH-1:0] used_reg;
    logic [SW-1:0]        head_reg, tail_reg, cur_reg, prev_reg;
    logic                 has_prev_reg;
    logic [CW-1:0]        count_reg, walk_reg;
    req_type_t            type_reg;
    logic [KeyWidth-1:0]  key_reg;
    logic [PW-1:0]        pay_reg;
    logic                 res_ok_reg;
    logic [KeyWidth-1:0]  res_key_reg;
    logic [PW-1:0]        res_pay_reg;

    // memory ports
    logic                 mem_we;
    logic [SW-1:0]        waddr, raddr;
    logic                 wr_entry;  // whole entry, else link only
    logic [SW-1:0]        wlink;
    logic [KeyWidth-1:0]  rd_key;
    logic [PW-1:0]        rd_pay;
    logic [SW-1:0]        rd_link;

    // lowest free slot
    logic [SW-1:0] free_slot;
    always_comb
    begin
        free_slot = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!used_reg[i]) free_slot = SW'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            link_mem[waddr] <= wlink;
            if (wr_entry) begin
                key_mem[waddr] <= key_reg;
                pay_mem[waddr] <= pay_reg;
            end
        end
        rd_key  <= key_mem[raddr];
        rd_pay  <= pay_mem[raddr];
        rd_link <= link_mem[raddr];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {1'b0, (count_reg == '0), 5'(count_reg),
                       32'(res_pay_reg), res_key_reg, res_ok_reg};

    always_comb
    begin
        mem_we   = 1'b0;
        wr_entry = 1'b0;
        waddr    = free_slot;
        wlink    = '0;
        raddr    = cur_reg;
        case (state_reg)
            S_READ: begin
                if (type_reg == REQ_ENQ && count_reg < CW'(QUEUE_DEPTH)) begin
                    mem_we   = 1'b1;
                    wr_entry = 1'b1;
                end
            end
            S_LINK: begin
                // tail link on enqueue, or bypass of removed entry
                mem_we = 1'b1;
                if (type_reg == REQ_ENQ) begin
                    waddr = tail_reg;
                    wlink = cur_reg;
                end else begin
                    waddr = prev_reg;
                    wlink = rd_link;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            res_ok_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        type_reg     <= req_type_t'(s_tuser);
                        key_reg      <= s_tdata[31:0];
                        pay_reg      <= s_tdata[32 +: PW];
                        cur_reg      <= head_reg;
                        has_prev_reg <= 1'b0;
                        walk_reg     <= '0;
                        res_ok_reg   <= 1'b0;
                        res_key_reg  <= '0;
                        res_pay_reg  <= '0;
                        state_reg    <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_OUT;
                    case (type_reg)
                        REQ_ENQ: begin
                            if (count_reg < CW'(QUEUE_DEPTH)) begin
                                used_reg[free_slot] <= 1'b1;
                                res_ok_reg <= 1'b1;
                                count_reg  <= count_reg + 1'b1;
                                if (count_reg == '0) begin
                                    head_reg <= free_slot;
                                    tail_reg <= free_slot;
                                end else begin
                                    cur_reg   <= free_slot;
                                    state_reg <= S_LINK;
                                end
                            end
                        end
                        REQ_DEQ, REQ_REMOVE: begin
                            if (walk_reg < count_reg) state_reg <= S_CHECK;
                        end
                        default: ;
                    endcase
                end
                S_CHECK: begin
                    // read data for cur_reg is valid here
                    if (type_reg == REQ_DEQ || rd_key == key_reg) begin
                        res_ok_reg  <= 1'b1;
                        res_key_reg <= rd_key;
                        res_pay_reg <= rd_pay;
                        used_reg[cur_reg] <= 1'b0;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_OUT;
                        if (count_reg == CW'(1)) begin
                            head_reg <= '0;
                            tail_reg <= '0;
                        end else if (!has_prev_reg) begin
                            head_reg <= rd_link;
                        end else begin
                            if (cur_reg == tail_reg) tail_reg <= prev_reg;
                            state_reg <= S_LINK;
                        end
                    end else begin
                        prev_reg     <= cur_reg;
                        has_prev_reg <= 1'b1;
                        cur_reg      <= rd_link;
                        walk_reg     <= walk_reg + 1'b1;
                        state_reg    <= S_READ;
                    end
                end
                S_LINK: begin
                    if (type_reg == REQ_ENQ) tail_reg <= cur_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/fjq_checker.sv */
`default_nettype none
`include "fifo_job_queue_with_keyed_removal_unit_assert.svh"
module fjq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);
    // result held while stalled
    `FJQ_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // empty flag agrees with count
    `FJQ_ASSERT_IMPL(a_empty, clk, rst_n, m_tvalid, m_tdata[70] == (m_tdata[69:65] == 5'd0))
    // failed request reports zero job
    `FJQ_ASSERT_IMPL(a_zero, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[64:1] == 64'd0)
    // one request at a time
    `FJQ_ASSERT_IMPL(a_excl, clk, rst_n, m_tvalid, !s_tready)
    // accepted request gets no result the next cycle
    `FJQ_ASSERT_NEXT(a_lat, clk, rst_n, s_tvalid && s_tready, !m_tvalid && !s_tready)
endmodule

bind fifo_job_queue_with_keyed_removal_unit fjq_checker u_fjq_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

/* verif/testbench.sv */
`default_nettype none
// Job queue with keyed removal: scoreboard plus driver tasks.
class job_queue_scoreboard;
    localparam int Depth = fjq_pkg::DefQueueDepth;

    // Expected results, oldest first: {empty, count, payload, key, ok}
    logic [70:0] pending_results[$];
    int unsigned fail_count;

    // Predicted contents, kept as an ordered list of jobs
    logic [31:0] held_keys[$];
    logic [31:0] held_payloads[$];

    function new();
        fail_count = 0;
    endfunction

    function int unsigned held();
        return held_keys.size();
    endfunction

    function void note_request(fjq_pkg::req_type_t kind, logic [31:0] key,
                               logic [31:0] payload);
        logic        ok;
        logic [31:0] okey;
        logic [31:0] opay;
        int          idx;
        ok = 1'b0;
        okey = '0;
        opay = '0;
        idx = -1;
        case (kind)
            fjq_pkg::REQ_ENQ:
            begin
                if (held_keys.size() < Depth)
                begin
                    held_keys.push_back(key);
                    held_payloads.push_back(payload);
                    ok = 1'b1;
                end
            end
            fjq_pkg::REQ_DEQ:
            begin
                if (held_keys.size() > 0)
                begin
                    okey = held_keys.pop_front();
                    opay = held_payloads.pop_front();
                    ok = 1'b1;
                end
            end
            fjq_pkg::REQ_REMOVE:
            begin
                foreach (held_keys[i])
                    if (idx < 0 && held_keys[i] == key)
                        idx = i;
                if (idx >= 0)
                begin
                    okey = held_keys[idx];
                    opay = held_payloads[idx];
                    held_keys.delete(idx);
                    held_payloads.delete(idx);
                    ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        pending_results.push_back({held_keys.size() == 0, 5'(held_keys.size()),
                                   opay, okey, ok});
    endfunction

    function void check_result(logic [71:0] word);
        logic [70:0] exp_word;
        if (pending_results.size() == 0)
        begin
            $error("result with nothing expected: %h", word);
            fail_count++;
            return;
        end
        exp_word = pending_results.pop_front();
        if (word[0] !== exp_word[0])
        begin
            $error("ok: expected %0d, got %0d", exp_word[0], word[0]);
            fail_count++;
        end
        if (word[32:1] !== exp_word[32:1])
        begin
            $error("out_key: expected %h, got %h", exp_word[32:1], word[32:1]);
            fail_count++;
        end
        if (word[64:33] !== exp_word[64:33])
        begin
            $error("out_payload: expected %h, got %h", exp_word[64:33], word[64:33]);
            fail_count++;
        end
        if (word[69:65] !== exp_word[69:65])
        begin
            $error("queue_count: expected %0d, got %0d", exp_word[69:65], word[69:65]);
            fail_count++;
        end
        if (word[70] !== exp_word[70])
        begin
            $error("queue_empty: expected %0d, got %0d", exp_word[70], word[70]);
            fail_count++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fjq_pkg::*;

    localparam int StallLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // job_key[31:0], job_payload[63:32]
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // ok, out_key, out_payload, queue_count, queue_empty

    job_queue_scoreboard board;
    bit          calm_phase;     // no idling on either side
    bit          hold_sink;      // receiver held off for the back-pressure test
    int unsigned quiet_cycles;
    // Keys recently enqueued, so that removals mostly hit
    logic [31:0] recent_keys[$];

    fifo_job_queue_with_keyed_removal_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle with a chance of about 23 in a hundred unless in the calm phase
    function automatic bit want_idle();
        return !calm_phase && ($urandom_range(99) < 23);
    endfunction

    // Offer one request and wait until it is taken; valid stays up afterwards
    task automatic send_request(req_type_t kind, logic [31:0] key, logic [31:0] payload);
        while (want_idle())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {payload, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(kind, key, payload);
        if (kind == REQ_ENQ)
        begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 24)
                void'(recent_keys.pop_front());
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic: keys drawn from a small pool so repeats happen
    task automatic random_request();
        int unsigned pick;
        logic [31:0] key;
        pick = $urandom_range(99);
        key = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(7));
        if (pick < 45)
            send_request(REQ_ENQ, key, $urandom());
        else if (pick < 70)
            send_request(REQ_DEQ, $urandom(), $urandom());
        else if (pick < 95)
        begin
            if (recent_keys.size() != 0 && $urandom_range(3) != 0)
                key = recent_keys[$urandom_range(recent_keys.size() - 1)];
            send_request(REQ_REMOVE, key, $urandom());
        end
        else
            send_request(REQ_NONE, $urandom(), $urandom());
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_sink && !want_idle();
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // Watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_sink)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("fifo_job_queue_with_keyed_removal_unit test failed");
            $finish;
        end
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_NONE;
        calm_phase = 1'b0;
        hold_sink = 1'b0;
        quiet_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dequeue, absent removal, unused type, extremes
        send_request(REQ_DEQ, 32'h0, 32'h0);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_ENQ, 32'h0, 32'h0);
        send_request(REQ_ENQ, 32'hFFFF_FFFF, 32'h1234_5678);
        // Duplicate key: the oldest goes first
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
        // Removing the tail, then the rest to empty
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_DEQ, 32'h0, 32'h0);
        send_request(REQ_DEQ, 32'h0, 32'h0);
        // Fill to capacity, then overflow, then remove from the middle
        for (int i = 0; i < 17; i++)
            send_request(REQ_ENQ, 32'(i + 100), $urandom());
        send_request(REQ_REMOVE, 32'd107, 32'h0);
        send_request(REQ_NONE, 32'h0, 32'h0);

        // Sender pauses until every result has come
        wait_drained();

        // Receiver held off long while the sender keeps offering
        hold_sink = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                random_request();
        join

        // Random traffic, with a calm stretch in the middle
        for (int i = 0; i < 1400; i++)
        begin
            calm_phase = (i >= 500 && i < 700);
            random_request();
        end
        calm_phase = 1'b0;

        wait_drained();
        repeat (50) @(posedge clk);
        if (board.fail_count == 0 && board.pending_results.size() == 0)
            $display("fifo_job_queue_with_keyed_removal_unit test passed");
        else
            $display("fifo_job_queue_with_keyed_removal_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
